[hw/rtl/fsla_pkg.sv]
// Shared types, constants and codes for the fixed-slot free-list allocator.
`default_nettype none

package fsla_pkg;

  // Pool geometry
  localparam int SLOTS      = 256;
  localparam int SLOT_W     = 8;               // slot index width
  localparam int LINK_W     = SLOT_W + 1;      // link width, holds the null code
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS);

  // Offset arithmetic
  localparam int GRAN_W     = 17;
  localparam int STRIDE_W   = GRAN_W + 1;
  localparam int PROD_W     = SLOT_W + STRIDE_W;
  localparam int OFF_W      = 24;
  localparam int HDR_BYTES  = 8;
  localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(64);

  // Commands
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;
    logic [OFF_W-1:0]  buffer_offset;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch input item, read link at head
    logic execute;   // update free list, load result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/fsla_ctrl.sv]
// Controller: sequences capture and execute, owns the result valid flag.
`default_nettype none

module fsla_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      fsla_pkg::ctrl_cmd_t cmd
);
  import fsla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  // result slot must be free, or drained this cycle
  assign cmd.execute = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fsla_dp.sv]
// Datapath: link memory, free head, granularity register, offset multiply.
`default_nettype none

module fsla_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fsla_pkg::ctrl_cmd_t          cmd,
  input  wire fsla_pkg::in_item_t           in_item,
  input  wire logic                         cfg_we,
  input  wire logic [fsla_pkg::GRAN_W-1:0]  cfg_data,
  output      fsla_pkg::out_item_t          out_item
);
  import fsla_pkg::*;

  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [SLOTS-1:0]  link_vld_r, link_vld_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [GRAN_W-1:0] gran_r;
  in_item_t          item_r;
  logic [LINK_W-1:0] rd_link_r;
  out_item_t         out_r, out_nxt;

  logic [SLOT_W-1:0]   top;
  logic                head_null;
  logic [LINK_W-1:0]   reset_link;
  logic [LINK_W-1:0]   eff_link;
  logic                rel_range;
  logic [STRIDE_W-1:0] gran_rnd;
  logic [STRIDE_W-1:0] stride;
  logic [PROD_W-1:0]   product;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [LINK_W-1:0]   wr_data;

  assign top       = head_r[SLOT_W-1:0];
  assign head_null = (head_r >= LINK_W'(SLOTS));
  // never-written entries read as their reset chain link
  assign reset_link = (top == SLOT_W'(SLOTS - 1)) ? LINK_NULL
                                                  : LINK_W'({1'b0, top} + LINK_W'(1));
  assign eff_link  = link_vld_r[top] ? rd_link_r : reset_link;
  assign rel_range = ({1'b0, item_r.slot_index} >= LINK_W'(SLOTS));

  // stride = header + granularity rounded up to 8
  assign gran_rnd = ({1'b0, gran_r} + STRIDE_W'(7)) & ~STRIDE_W'(7);
  assign stride   = gran_rnd + STRIDE_W'(HDR_BYTES);
  assign product  = PROD_W'(top) * PROD_W'(stride);

  always_comb begin
    head_nxt     = head_r;
    link_vld_nxt = link_vld_r;
    out_nxt      = '0;
    wr_en        = 1'b0;
    wr_addr      = top;
    wr_data      = LINK_NULL;
    if (item_r.command == CMD_ALLOC) begin
      if (head_null) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.status        = ST_OK;
        out_nxt.granted_slot  = top;
        out_nxt.buffer_offset = OFF_W'(product + PROD_W'(HDR_BYTES));
        head_nxt              = eff_link;
        wr_en                 = 1'b1;
        wr_addr               = top;
        wr_data               = LINK_NULL;
      end
    end else begin
      if (rel_range) begin
        out_nxt.status = ST_RANGE;
      end else begin
        out_nxt.status = ST_OK;
        head_nxt       = {1'b0, item_r.slot_index};
        wr_en          = 1'b1;
        wr_addr        = item_r.slot_index;
        wr_data        = head_r;
      end
    end
    if (wr_en) begin
      link_vld_nxt[wr_addr] = 1'b1;
    end
  end

  // link memory: one write, one registered read per item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_link_r <= link_mem[head_r[SLOT_W-1:0]];
    end
    if (cmd.execute && wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      link_vld_r <= '0;
      gran_r     <= GRAN_RESET;
    end else begin
      if (cmd.execute) begin
        head_r     <= head_nxt;
        link_vld_r <= link_vld_nxt;
      end
      if (cfg_we) begin
        gran_r <= cfg_data;
      end
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

[hw/rtl/fixed_slot_free_list_allocator_top.sv]
// Top level of the fixed-slot free-list allocator: controller, datapath, checks.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-------------------------------------
//   in      | in_valid / in_ready            | in_item: command, slot_index
//   out     | out_valid / out_ready          | out_item: status, granted_slot,
//           |                                |           buffer_offset
//   cfg     | cfg_valid / cfg_ready (always) | cfg_data: slot_granularity
//
// Each command is first captured, reading the head slot's link from the
// link memory (registered read), then executed, updating the free head and
// the link memory and loading the result register.
// Reset is synchronous; after reset the block takes items at once. Links not
// yet written read as their index-order chain through per-slot valid bits,
// so there is no clearing pass.
// A result waiting in the output register does not block the next transfer
// in; that item stalls in its update cycle until the result is taken.
`default_nettype none

module fixed_slot_free_list_allocator_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire fsla_pkg::in_item_t           in_item,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      fsla_pkg::out_item_t          out_item,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [fsla_pkg::GRAN_W-1:0]  cfg_data
);
  import fsla_pkg::*;

  ctrl_cmd_t cmd;

  // register writes must arrive only while idle (not enforced here), so always take them
  assign cfg_ready = 1'b1;

  fsla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fsla_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

  // capture and update never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

  // an accepted item blocks the input for its update cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer in");

  // a new result only appears after an update
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.execute))
    else $error("result valid without an update");

  // failed commands carry no slot and no offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |->
      (out_item.granted_slot == '0) && (out_item.buffer_offset == '0))
    else $error("failed command returned a slot");

endmodule

`default_nettype wire

[sim/fsla_checker.sv]
// Result checker for the free-list slot allocator: mirrors the pool and compares every result.
`default_nettype none

module fsla_checker
  import fsla_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire in_item_t            in_item,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire out_item_t           out_item,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [GRAN_W-1:0]   cfg_data,
  output int                       mismatches,
  output int                       awaiting,
  output int                       results_seen,
  output int                       empty_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the free stack and the granularity register
  logic [LINK_W-1:0] next_free [SLOTS];
  logic [LINK_W-1:0] pool_top;
  logic [GRAN_W-1:0] granularity;
  out_item_t         pending_results [$];

  function automatic void reset_pool();
    for (int s = 0; s < SLOTS; s++)
      next_free[s] = (s + 1 < SLOTS) ? LINK_W'(s + 1) : LINK_NULL;
    pool_top    = '0;
    granularity = GRAN_RESET;
  endfunction

  function automatic logic [OFF_W-1:0] payload_offset(logic [SLOT_W-1:0] slot);
    logic [STRIDE_W-1:0] rounded;
    logic [31:0]         span;
    rounded = (STRIDE_W'(granularity) + STRIDE_W'(7)) & ~STRIDE_W'(7);
    span    = 32'(slot) * (32'(rounded) + 32'(HDR_BYTES)) + 32'(HDR_BYTES);
    return span[OFF_W-1:0];
  endfunction

  // Applies one command to the shadow pool and returns the result it must give
  function automatic out_item_t apply_pool_command(in_item_t item);
    out_item_t           res;
    logic [LINK_W-1:0]   top;
    res = '0;
    if (item.command == CMD_ALLOC) begin
      top = pool_top;
      if (top >= LINK_NULL) begin
        res.status = ST_EMPTY;
      end else begin
        pool_top                       = next_free[top[SLOT_W-1:0]];
        next_free[top[SLOT_W-1:0]]     = LINK_NULL;
        res.granted_slot               = top[SLOT_W-1:0];
        res.buffer_offset              = payload_offset(top[SLOT_W-1:0]);
      end
    end else if (LINK_W'(item.slot_index) >= LINK_NULL) begin
      res.status = ST_RANGE;
    end else begin
      next_free[item.slot_index] = pool_top;
      pool_top                   = LINK_W'(item.slot_index);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      reset_pool();
      pending_results.delete();
    end else begin
      // results first, so a result can never consume the expectation made at this edge
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] result with none outstanding: status %0d slot %0d offset 0x%06h",
                     $realtime, out_item.status, out_item.granted_slot,
                     out_item.buffer_offset);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (want.status == ST_EMPTY) empty_seen++;
          if (out_item.status !== want.status || out_item.granted_slot !== want.granted_slot ||
              out_item.buffer_offset !== want.buffer_offset) begin
            if (mismatches < 10)
              $display("[%0t] mismatch exp/got: status %0d/%0d slot %0d/%0d offset %06h/%06h",
                       $realtime,
                       want.status, out_item.status, want.granted_slot, out_item.granted_slot,
                       want.buffer_offset, out_item.buffer_offset);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_pool_command(in_item));
      if (cfg_valid && cfg_ready)
        granularity = cfg_data;
    end
    awaiting = pending_results.size();
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench top for the free-list slot allocator: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fsla_pkg::*;

  // Leave a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 500_000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [GRAN_W-1:0] cfg_data;

  int mismatches;
  int awaiting;
  int results_seen;
  int empty_seen;
  int cycles;
  int items_sent;
  int cfg_writes;

  // Burst flags: while set, that side neither gaps nor stalls
  bit in_burst;
  bit out_burst;

  // Which slots this bench currently owns, tracked in result order so that
  // random releases can hand back real allocations.
  bit       slot_held [SLOTS];
  in_item_t issued_cmds [$];

  fixed_slot_free_list_allocator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fsla_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .results_seen (results_seen),
    .empty_seen   (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycles, awaiting);
      $display("Some tests failed");
      $finish;
    end
  end

  // Ownership ledger: commands are matched to results in order, so a grant
  // sets its slot and a good release clears it.
  always @(posedge clk) begin
    in_item_t done;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        done = issued_cmds.pop_front();
        if (out_item.status == ST_OK) begin
          if (done.command == CMD_ALLOC) slot_held[out_item.granted_slot] = 1'b1;
          else                           slot_held[done.slot_index]      = 1'b0;
        end
      end
      if (in_valid && in_ready) issued_cmds.push_back(in_item);
    end
  end

  // Result side: random stall before each transfer, with burst stretches
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 47) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // One command transfer. Called and returns at a falling edge; valid stays
  // high afterwards so back-to-back items need no second assignment.
  task automatic send_cmd(input logic cmd, input logic [SLOT_W-1:0] idx);
    int gap;
    if ($urandom_range(0, 47) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {cmd, idx};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // Granularity changes only with the block idle
  task automatic write_granularity(input logic [GRAN_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic int pick_held_slot();
    int start;
    int k;
    start = $urandom_range(0, SLOTS - 1);
    for (k = 0; k < SLOTS; k++)
      if (slot_held[(start + k) % SLOTS]) return (start + k) % SLOTS;
    return -1;
  endfunction

  // Mostly well-formed traffic: allocates, releases of owned slots, and a
  // share of releases at random indexes (stray and double releases).
  task automatic run_phase(input int count, input int alloc_pct, input int noise_pct);
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_cmd(CMD_ALLOC, 8'($urandom()));
      end else if ($urandom_range(0, 99) < noise_pct) begin
        send_cmd(CMD_RELEASE, 8'($urandom()));
      end else begin
        pick = pick_held_slot();
        if (pick < 0) begin
          send_cmd(CMD_RELEASE, 8'($urandom()));
        end else begin
          slot_held[pick] = 1'b0;   // keep it from being picked twice in flight
          send_cmd(CMD_RELEASE, SLOT_W'(pick));
        end
      end
    end
  endtask

  initial begin : stimulus
    int                free_slots [$];
    int                i;
    int                j;
    int                swap;
    logic [GRAN_W-1:0] phase_gran [6];
    int                phase_len  [6];
    int                phase_alloc[6];
    int                phase_noise[6];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // Reset granularity of 64: stride 72, first slots at 8 and 80
    send_cmd(CMD_ALLOC, 8'hFF);            // slot field ignored on allocate
    send_cmd(CMD_ALLOC, 8'h00);
    send_cmd(CMD_ALLOC, 8'h5A);
    send_cmd(CMD_RELEASE, 8'd1);           // push back, comes out next
    send_cmd(CMD_ALLOC, 8'hA5);
    send_cmd(CMD_RELEASE, 8'hFF);          // top slot while it is still free
    write_granularity(17'd0);              // zero: slots 8 bytes apart
    send_cmd(CMD_ALLOC, 8'h00);
    write_granularity(17'h1FFFF);          // above range: offset wraps at 24 bits
    send_cmd(CMD_RELEASE, 8'hFF);
    send_cmd(CMD_ALLOC, 8'h00);
    write_granularity(17'd1);              // rounds up to 8
    send_cmd(CMD_ALLOC, 8'h00);
    write_granularity(17'h10000);          // largest legal granularity
    send_cmd(CMD_ALLOC, 8'h00);
    // Double release of slot 0 makes it link to itself; two pops then
    // clear the link and leave the pool empty
    send_cmd(CMD_RELEASE, 8'd0);
    send_cmd(CMD_RELEASE, 8'd0);
    send_cmd(CMD_ALLOC, 8'h00);
    send_cmd(CMD_ALLOC, 8'h00);
    send_cmd(CMD_ALLOC, 8'h00);            // pool empty
    send_cmd(CMD_ALLOC, 8'hFF);            // still empty

    // ---- refill: release every slot not owned, in random order ----
    wait_idle();
    for (i = 0; i < SLOTS; i++)
      if (!slot_held[i]) free_slots.push_back(i);
    for (i = free_slots.size() - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      swap          = free_slots[i];
      free_slots[i] = free_slots[j];
      free_slots[j] = swap;
    end
    foreach (free_slots[k]) send_cmd(CMD_RELEASE, SLOT_W'(free_slots[k]));

    // ---- random phases, granularity changed between them with slots out ----
    phase_gran  = '{17'($urandom_range(2, 65535)), 17'd0, 17'h1FFFF,
                    17'($urandom_range(2, 65535)), 17'h10000, 17'd1};
    phase_len   = '{280, 200, 180, 120, 120, 100};
    phase_alloc = '{96,  25,  55,  50,  70,  40};   // first phase drains the pool
    phase_noise = '{0,   0,   0,   10,  10,  20};
    for (i = 0; i < 6; i++) begin
      write_granularity(phase_gran[i]);
      run_phase(phase_len[i], phase_alloc[i], phase_noise[i]);
    end

    // ---- wind down: all results in, then a short quiet window ----
    wait_idle();
    repeat (8) @(negedge clk);

    $display("Run covered %0d command transfers, %0d results (%0d on an empty pool)",
             items_sent, results_seen, empty_seen);
    $display("across %0d granularity writes, with %0d mismatches", cfg_writes, mismatches);
    if (mismatches == 0 && awaiting == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/fsla_pkg.sv
hw/rtl/fsla_ctrl.sv
hw/rtl/fsla_dp.sv
hw/rtl/fixed_slot_free_list_allocator_top.sv
sim/fsla_checker.sv
sim/tb_top.sv
